[rtl/core/cmfp_pkg.sv]
// ---------------------------------------------------------------------------
// cmfp_pkg: shared types and constants of the message frame parser
// Field codes, verdict codes, register indexes and the result word layout.
// ---------------------------------------------------------------------------
package cmfp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [7:0]  MAX_MSG_TYPE_RST    = 8'd15;
    localparam logic [7:0]  MAX_ENTRY_TYPE_RST  = 8'd4;
    localparam logic [31:0] MAX_ENTRIES_RST     = 32'd100000;
    localparam logic [31:0] MAX_PEERS_RST       = 32'd16;
    localparam logic [31:0] MAX_FRAME_BYTES_RST = 32'd16777216;

    localparam logic [2:0] REG_MAX_MSG_TYPE    = 3'd0;
    localparam logic [2:0] REG_MAX_ENTRY_TYPE  = 3'd1;
    localparam logic [2:0] REG_MAX_ENTRIES     = 3'd2;
    localparam logic [2:0] REG_MAX_PEERS       = 3'd3;
    localparam logic [2:0] REG_MAX_FRAME_BYTES = 3'd4;

    // Header field numbers that carry a check or a count.
    localparam logic [3:0] HF_MSG_TYPE    = 4'd0;
    localparam logic [3:0] HF_FLAG_A      = 4'd10;
    localparam logic [3:0] HF_ENTRY_COUNT = 4'd11;
    localparam logic [3:0] HF_SNAP_SIZE   = 4'd12;
    localparam logic [3:0] HF_FLAG_B      = 4'd14;
    localparam logic [3:0] HF_PEER_COUNT  = 4'd15;

    // Entry header field numbers that carry a check or a count.
    localparam logic [2:0] EF_TYPE     = 3'd2;
    localparam logic [2:0] EF_DATA_LEN = 3'd5;

    localparam logic [4:0] FC_ENT_BASE  = 5'd16;
    localparam logic [4:0] FC_ENT_BYTE  = 5'd22;
    localparam logic [4:0] FC_SNAP_BYTE = 5'd23;
    localparam logic [4:0] FC_PEER_BASE = 5'd24;
    localparam logic [4:0] FC_VERDICT   = 5'd26;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNC     = 4'd1;
    localparam logic [3:0] ST_MSG_TYPE  = 4'd2;
    localparam logic [3:0] ST_FLAG      = 4'd3;
    localparam logic [3:0] ST_ENTRIES   = 4'd4;
    localparam logic [3:0] ST_PEERS     = 4'd5;
    localparam logic [3:0] ST_ENT_TYPE  = 4'd6;
    localparam logic [3:0] ST_TRAILING  = 4'd7;
    localparam logic [3:0] ST_OVERSIZE  = 4'd8;

    typedef struct packed {
        logic [7:0]  max_msg_type;
        logic [7:0]  max_entry_type;
        logic [31:0] max_entries;
        logic [31:0] peer_limit;
        logic [31:0] max_frame_bytes;
    } t_cfg;

    // One result: fields as on the output port.
    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic [31:0] index;
        logic [3:0]  status;
    } t_res;

    // One queue word: up to two results from one byte.
    typedef struct packed {
        logic  two;
        t_res  r0;
        t_res  r1;
    } t_qword;

    function automatic logic [3:0] hdr_size(input logic [3:0] f);
        case (f)
            HF_MSG_TYPE, HF_FLAG_A, HF_FLAG_B: hdr_size = 4'd1;
            HF_ENTRY_COUNT, HF_SNAP_SIZE, HF_PEER_COUNT: hdr_size = 4'd4;
            default: hdr_size = 4'd8;
        endcase
    endfunction

    function automatic logic [3:0] ent_size(input logic [2:0] f);
        case (f)
            EF_TYPE: ent_size = 4'd1;
            EF_DATA_LEN: ent_size = 4'd4;
            default: ent_size = 4'd8;
        endcase
    endfunction

endpackage

[rtl/core/cmfp_front.sv]
// ---------------------------------------------------------------------------
// cmfp_front: byte parser
// A byte per cycle while the queue has room; runs frame state, builds results.
// ---------------------------------------------------------------------------
module cmfp_front #(
    parameter int COUNT_WIDTH = cmfp_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  cmfp_pkg::t_cfg   i_cfg,
    output logic             o_qvalid,
    input  logic             i_qready,
    output cmfp_pkg::t_qword o_qword
);

    typedef enum logic [2:0] {
        PH_HDR, PH_ENT, PH_EDATA, PH_SNAP, PH_PEER, PH_DONE, PH_DISCARD
    } t_phase;

    localparam logic [63:0] COUNT_MAX = 64'((65'd1 << COUNT_WIDTH) - 65'd1);

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_fbc, n_fbc;
    logic [63:0]            r_shift, n_shift;
    logic [3:0]             r_fnum, n_fnum;
    logic [COUNT_WIDTH-1:0] r_ent_left, n_ent_left;
    logic [COUNT_WIDTH-1:0] r_pay_left, n_pay_left;
    logic [COUNT_WIDTH-1:0] r_snap_size, n_snap_size;
    logic [COUNT_WIDTH-1:0] r_peer_left, n_peer_left;
    logic [31:0]            r_elem, n_elem;
    logic [31:0]            r_total;
    logic [3:0]             r_err, n_err;

    logic        take;
    logic [31:0] total;
    logic [63:0] v;
    logic        nres;
    cmfp_pkg::t_res res0;
    cmfp_pkg::t_qword qw;

    assign o_ready  = i_qready;
    assign take     = i_valid && i_qready;
    assign total    = (r_total == 32'hFFFF_FFFF) ? r_total : r_total + 32'd1;
    assign v        = {r_shift[55:0], i_byte};

    always_comb begin
        n_phase = r_phase; n_fbc = r_fbc; n_shift = r_shift; n_fnum = r_fnum;
        n_ent_left = r_ent_left; n_pay_left = r_pay_left;
        n_snap_size = r_snap_size; n_peer_left = r_peer_left;
        n_elem = r_elem; n_err = r_err;
        nres = 1'b0;
        res0 = '0;
        if (r_err == cmfp_pkg::ST_OK && total > i_cfg.max_frame_bytes) begin
            n_err = cmfp_pkg::ST_OVERSIZE; n_phase = PH_DISCARD;
        end else if (r_err == cmfp_pkg::ST_OK) begin
            unique case (r_phase)
                PH_HDR: begin
                    if (r_fbc + 4'd1 < cmfp_pkg::hdr_size(r_fnum)) begin
                        n_shift = v; n_fbc = r_fbc + 4'd1;
                    end else begin
                        n_shift = '0; n_fbc = '0; n_fnum = r_fnum + 4'd1;
                        nres = 1'b1;
                        res0.code = {1'b0, r_fnum}; res0.value = v;
                        if (r_fnum == cmfp_pkg::HF_MSG_TYPE &&
                            v > 64'(i_cfg.max_msg_type)) begin
                            n_err = cmfp_pkg::ST_MSG_TYPE; n_phase = PH_DISCARD;
                        end else if ((r_fnum == cmfp_pkg::HF_FLAG_A ||
                                      r_fnum == cmfp_pkg::HF_FLAG_B) && v > 64'd1) begin
                            n_err = cmfp_pkg::ST_FLAG; n_phase = PH_DISCARD;
                        end else if (r_fnum == cmfp_pkg::HF_ENTRY_COUNT) begin
                            if (v > 64'(i_cfg.max_entries) || v > COUNT_MAX) begin
                                n_err = cmfp_pkg::ST_ENTRIES; n_phase = PH_DISCARD;
                            end else n_ent_left = COUNT_WIDTH'(v);
                        end else if (r_fnum == cmfp_pkg::HF_SNAP_SIZE) begin
                            if (v > COUNT_MAX) begin
                                n_err = cmfp_pkg::ST_OVERSIZE; n_phase = PH_DISCARD;
                            end else n_snap_size = COUNT_WIDTH'(v);
                        end else if (r_fnum == cmfp_pkg::HF_PEER_COUNT) begin
                            if (v > 64'(i_cfg.peer_limit) || v > COUNT_MAX) begin
                                n_err = cmfp_pkg::ST_PEERS; n_phase = PH_DISCARD;
                            end else begin
                                n_peer_left = COUNT_WIDTH'(v);
                                n_fnum = '0; n_elem = '0;
                                if (r_ent_left != '0) n_phase = PH_ENT;
                                else if (r_snap_size != '0) begin
                                    n_pay_left = r_snap_size; n_phase = PH_SNAP;
                                end else
                                    n_phase = (v != 64'd0) ? PH_PEER : PH_DONE;
                            end
                        end
                    end
                end
                PH_ENT: begin
                    if (r_fbc + 4'd1 < cmfp_pkg::ent_size(r_fnum[2:0])) begin
                        n_shift = v; n_fbc = r_fbc + 4'd1;
                    end else begin
                        n_shift = '0; n_fbc = '0; n_fnum = r_fnum + 4'd1;
                        nres = 1'b1;
                        res0.code = cmfp_pkg::FC_ENT_BASE + {2'b0, r_fnum[2:0]};
                        res0.value = v; res0.index = r_elem;
                        if (r_fnum[2:0] == cmfp_pkg::EF_TYPE &&
                            v > 64'(i_cfg.max_entry_type)) begin
                            n_err = cmfp_pkg::ST_ENT_TYPE; n_phase = PH_DISCARD;
                        end else if (r_fnum[2:0] == cmfp_pkg::EF_DATA_LEN) begin
                            if (v > COUNT_MAX) begin
                                n_err = cmfp_pkg::ST_OVERSIZE; n_phase = PH_DISCARD;
                            end else begin
                                n_pay_left = COUNT_WIDTH'(v); n_fnum = '0;
                                if (v != 64'd0) n_phase = PH_EDATA;
                                else begin
                                    n_ent_left = r_ent_left - COUNT_WIDTH'(1);
                                    n_elem = r_elem + 32'd1;
                                    if (r_ent_left != COUNT_WIDTH'(1)) n_phase = PH_ENT;
                                    else if (r_snap_size != '0) begin
                                        n_pay_left = r_snap_size; n_phase = PH_SNAP;
                                    end else begin
                                        n_elem = '0;
                                        n_phase = (r_peer_left != '0) ? PH_PEER : PH_DONE;
                                    end
                                end
                            end
                        end
                    end
                end
                PH_EDATA: begin
                    nres = 1'b1;
                    res0.code = cmfp_pkg::FC_ENT_BYTE;
                    res0.value = {56'd0, i_byte}; res0.index = r_elem;
                    n_pay_left = r_pay_left - COUNT_WIDTH'(1);
                    if (r_pay_left == COUNT_WIDTH'(1)) begin
                        n_ent_left = r_ent_left - COUNT_WIDTH'(1);
                        n_elem = r_elem + 32'd1;
                        if (r_ent_left != COUNT_WIDTH'(1)) n_phase = PH_ENT;
                        else if (r_snap_size != '0) begin
                            n_pay_left = r_snap_size; n_phase = PH_SNAP;
                        end else begin
                            n_elem = '0;
                            n_phase = (r_peer_left != '0) ? PH_PEER : PH_DONE;
                        end
                    end
                end
                PH_SNAP: begin
                    nres = 1'b1;
                    res0.code = cmfp_pkg::FC_SNAP_BYTE;
                    res0.value = {56'd0, i_byte};
                    n_pay_left = r_pay_left - COUNT_WIDTH'(1);
                    if (r_pay_left == COUNT_WIDTH'(1)) begin
                        n_elem = '0; n_fnum = '0;
                        n_phase = (r_peer_left != '0) ? PH_PEER : PH_DONE;
                    end
                end
                PH_PEER: begin
                    if (!r_fnum[0] && r_fbc + 4'd1 < 4'd8) begin
                        n_shift = v; n_fbc = r_fbc + 4'd1;
                    end else begin
                        n_shift = '0; n_fbc = '0; n_fnum = {3'd0, ~r_fnum[0]};
                        nres = 1'b1;
                        res0.code = cmfp_pkg::FC_PEER_BASE + {4'd0, r_fnum[0]};
                        res0.value = v; res0.index = r_elem;
                        if (r_fnum[0]) begin
                            if (v > 64'd1) begin
                                n_err = cmfp_pkg::ST_FLAG; n_phase = PH_DISCARD;
                            end else begin
                                n_peer_left = r_peer_left - COUNT_WIDTH'(1);
                                n_elem = r_elem + 32'd1;
                                if (r_peer_left == COUNT_WIDTH'(1)) n_phase = PH_DONE;
                            end
                        end
                    end
                end
                PH_DONE: begin
                    n_err = cmfp_pkg::ST_TRAILING; n_phase = PH_DISCARD;
                end
                default: ;
            endcase
        end
        if (i_end && n_err == cmfp_pkg::ST_OK && n_phase != PH_DONE)
            n_err = cmfp_pkg::ST_TRUNC;
    end

    // Verdict result, placed after the field result if there is one.
    always_comb begin
        cmfp_pkg::t_res vr;
        vr.code = cmfp_pkg::FC_VERDICT; vr.value = {32'd0, total};
        vr.index = '0; vr.status = n_err;
        qw.two = nres && i_end;
        qw.r0  = nres ? res0 : vr;
        qw.r1  = vr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_fbc <= '0; r_shift <= '0; r_fnum <= '0;
            r_ent_left <= '0; r_pay_left <= '0; r_snap_size <= '0;
            r_peer_left <= '0; r_elem <= '0; r_total <= '0; r_err <= '0;
            o_qvalid <= 1'b0;
        end else begin
            if (i_qready) o_qvalid <= take && (nres || i_end);
            if (take) begin
                o_qword <= qw;
                if (i_end) begin
                    r_phase <= PH_HDR; r_fbc <= '0; r_shift <= '0; r_fnum <= '0;
                    r_ent_left <= '0; r_pay_left <= '0; r_snap_size <= '0;
                    r_peer_left <= '0; r_elem <= '0; r_total <= '0; r_err <= '0;
                end else begin
                    r_phase <= n_phase; r_fbc <= n_fbc; r_shift <= n_shift;
                    r_fnum <= n_fnum; r_ent_left <= n_ent_left;
                    r_pay_left <= n_pay_left; r_snap_size <= n_snap_size;
                    r_peer_left <= n_peer_left; r_elem <= n_elem;
                    r_total <= total; r_err <= n_err;
                end
            end
        end
    end

    a_err_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != cmfp_pkg::ST_OK) |-> (r_phase == PH_DISCARD))
        else $error("error latched outside discard phase");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_qvalid && !i_qready) |=> (o_qvalid && $stable(o_qword)))
        else $error("queue word changed while stalled");
    a_reset_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_end) |=> (r_total == 32'd0 && r_phase == PH_HDR))
        else $error("frame state not cleared after frame end");

endmodule

[rtl/core/cmfp_back.sv]
// ---------------------------------------------------------------------------
// cmfp_back: result issue
// Two-entry queue of result words; issues one or two results per word.
// ---------------------------------------------------------------------------
module cmfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_qvalid,
    output logic             o_qready,
    input  cmfp_pkg::t_qword i_qword,
    output logic             o_valid,
    input  logic             i_ready,
    output cmfp_pkg::t_res   o_res,
    output logic             o_last
);

    cmfp_pkg::t_qword r_mem [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr, r_half;
    logic       push, pop, wlast;

    assign o_qready = (r_cnt != 2'd2);
    assign push     = i_qvalid && o_qready;
    assign o_valid  = (r_cnt != 2'd0);
    assign wlast    = !r_mem[r_rd].two || r_half;
    assign o_res    = r_half ? r_mem[r_rd].r1 : r_mem[r_rd].r0;
    assign o_last   = wlast;
    assign pop      = o_valid && i_ready && wlast;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_qword;
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0; r_half <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            if (o_valid && i_ready) r_half <= !wlast;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (o_valid && r_mem[r_rd].two))
        else $error("second result without a two-result word");

endmodule

[rtl/core/consensus_message_frame_parser.sv]
// ---------------------------------------------------------------------------
// consensus_message_frame_parser: streaming consensus message frame parser
// Parses a byte stream frame by frame and emits tagged fields and a verdict.
// ---------------------------------------------------------------------------
// One byte is taken per cycle with no gaps while the output side keeps up.
// A byte yields up to two result words (a field and, on the last byte, the
// verdict), registered in the parser and then put in the two-entry queue
// between parser and output, which absorbs a byte that yields two results.
// Configuration must be written only when idle; the block does not check this.
module consensus_message_frame_parser #(
    parameter int COUNT_WIDTH = cmfp_pkg::COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // frame_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [4:0] field_code, [68:5] field_value, [100:69] item_index, [104:101] status
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast,   // last
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    cmfp_pkg::t_cfg   r_cfg;
    cmfp_pkg::t_qword qword;
    cmfp_pkg::t_res   res;
    logic             qvalid, qready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_msg_type    <= cmfp_pkg::MAX_MSG_TYPE_RST;
            r_cfg.max_entry_type  <= cmfp_pkg::MAX_ENTRY_TYPE_RST;
            r_cfg.max_entries     <= cmfp_pkg::MAX_ENTRIES_RST;
            r_cfg.peer_limit      <= cmfp_pkg::MAX_PEERS_RST;
            r_cfg.max_frame_bytes <= cmfp_pkg::MAX_FRAME_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cmfp_pkg::REG_MAX_MSG_TYPE:    r_cfg.max_msg_type <= i_cfg_data[7:0];
                cmfp_pkg::REG_MAX_ENTRY_TYPE:  r_cfg.max_entry_type <= i_cfg_data[7:0];
                cmfp_pkg::REG_MAX_ENTRIES:     r_cfg.max_entries <= i_cfg_data;
                cmfp_pkg::REG_MAX_PEERS:       r_cfg.peer_limit <= i_cfg_data;
                cmfp_pkg::REG_MAX_FRAME_BYTES: r_cfg.max_frame_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmfp_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_end(s_axis_tlast), .i_cfg(r_cfg),
        .o_qvalid(qvalid), .i_qready(qready), .o_qword(qword)
    );

    cmfp_back u_back (
        .i_clk, .i_rst_n,
        .i_qvalid(qvalid), .o_qready(qready), .i_qword(qword),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_res(res), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, res.status, res.index, res.value, res.code};

endmodule

[tb/tb_consensus_message_frame_parser.sv]
// ---------------------------------------------------------------------------
// tb_consensus_message_frame_parser: self-checking testbench of the frame parser
// Drives frames byte by byte, predicts every tagged field and verdict, and
// compares each output word with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_consensus_message_frame_parser;

    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_BYTES = 160;

    typedef enum logic [2:0] {
        S_HEADER, S_ENTRY, S_EDATA, S_SNAP, S_PEER, S_DONE, S_DISCARD
    } t_parse_state;

    typedef struct {
        cmfp_pkg::t_res r;
        logic lst;
    } t_field_word;

    typedef struct {
        logic [7:0] b;
        logic       e;
        logic       chk;
        logic [3:0] st;
        int         len;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = 3'd0;
    logic [31:0]  i_cfg_data = 32'd0;

    consensus_message_frame_parser u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and the parse state.
    logic [7:0]   c_msg_type, c_ent_type;
    logic [31:0]  c_entries, c_peers, c_frame;
    t_parse_state ps;
    logic [3:0]   fbc, err;
    logic [63:0]  shift;
    logic [4:0]   fld;
    logic [31:0]  ent_left, pay_left, snap_size, peer_left, elem, tot;

    t_field_word  step_fields[$];
    t_field_word  expected_fields[$];
    logic [7:0]   frame_bytes[$];
    int           failures = 0;
    int           idle_cycles = 0;
    logic         rx_steady = 1'b0;
    logic         tx_steady = 1'b0;

    function automatic int hdr_len(input logic [3:0] f);
        if (f == cmfp_pkg::HF_MSG_TYPE || f == cmfp_pkg::HF_FLAG_A ||
            f == cmfp_pkg::HF_FLAG_B) return 1;
        if (f == cmfp_pkg::HF_ENTRY_COUNT || f == cmfp_pkg::HF_SNAP_SIZE ||
            f == cmfp_pkg::HF_PEER_COUNT) return 4;
        return 8;
    endfunction

    function automatic int ent_len(input logic [4:0] f);
        if (f == 5'(cmfp_pkg::EF_TYPE)) return 1;
        if (f == 5'(cmfp_pkg::EF_DATA_LEN)) return 4;
        return 8;
    endfunction

    task automatic add_field(input logic [4:0] c, input logic [63:0] v,
                             input logic [31:0] ix, input logic [3:0] st);
        t_field_word w;
        w.r.code = c;
        w.r.value = v;
        w.r.index = ix;
        w.r.status = st;
        w.lst = 1'b0;
        step_fields.push_back(w);
    endtask

    task automatic abort_frame(input logic [3:0] code);
        err = code;
        ps = S_DISCARD;
    endtask

    task automatic clear_frame();
        ps = S_HEADER; fbc = 0; shift = 0; fld = 0; ent_left = 0; pay_left = 0;
        snap_size = 0; peer_left = 0; elem = 0; tot = 0; err = cmfp_pkg::ST_OK;
    endtask

    task automatic to_peers();
        elem = 0;
        fld = 0;
        ps = (peer_left > 0) ? S_PEER : S_DONE;
    endtask

    task automatic after_entries();
        if (snap_size > 0) begin
            pay_left = snap_size;
            ps = S_SNAP;
        end else begin
            to_peers();
        end
    endtask

    task automatic next_entry();
        ent_left = ent_left - 32'd1;
        elem = elem + 32'd1;
        fld = 0;
        if (ent_left > 0) ps = S_ENTRY;
        else after_entries();
    endtask

    // Works out the fields that one accepted byte causes.
    task automatic parse_byte(input logic [7:0] b, input logic e);
        int          sz;
        logic [4:0]  f;
        logic [63:0] v;
        logic        done;
        step_fields.delete();
        sz = 0;
        done = 1'b0;
        f = 0;
        v = 0;
        if (tot != 32'hFFFF_FFFF) tot = tot + 32'd1;
        if (err == cmfp_pkg::ST_OK && tot > c_frame) abort_frame(cmfp_pkg::ST_OVERSIZE);
        if (err == cmfp_pkg::ST_OK) begin
            case (ps)
                S_HEADER: begin f = {1'b0, fld[3:0]}; sz = hdr_len(fld[3:0]); end
                S_ENTRY: begin f = (fld > 5'd5) ? 5'd5 : fld; sz = ent_len(f); end
                S_PEER: begin f = {4'd0, fld[0]}; sz = f[0] ? 1 : 8; end
                default: sz = 0;
            endcase
            if (sz != 0) begin
                shift = {shift[55:0], b};
                fbc = fbc + 4'd1;
                if (fbc >= sz) begin
                    done = 1'b1;
                    v = shift;
                    shift = 0;
                    fbc = 0;
                    fld = f + 5'd1;
                end
            end
            case (ps)
                S_HEADER: if (done) begin
                    add_field(f, v, 0, cmfp_pkg::ST_OK);
                    if (f == 5'(cmfp_pkg::HF_MSG_TYPE) && v > c_msg_type)
                        abort_frame(cmfp_pkg::ST_MSG_TYPE);
                    else if ((f == 5'(cmfp_pkg::HF_FLAG_A) || f == 5'(cmfp_pkg::HF_FLAG_B))
                             && v > 1)
                        abort_frame(cmfp_pkg::ST_FLAG);
                    else if (f == 5'(cmfp_pkg::HF_ENTRY_COUNT) && v > c_entries)
                        abort_frame(cmfp_pkg::ST_ENTRIES);
                    else if (f == 5'(cmfp_pkg::HF_PEER_COUNT) && v > c_peers)
                        abort_frame(cmfp_pkg::ST_PEERS);
                    else begin
                        if (f == 5'(cmfp_pkg::HF_ENTRY_COUNT)) ent_left = v[31:0];
                        if (f == 5'(cmfp_pkg::HF_SNAP_SIZE)) snap_size = v[31:0];
                        if (f == 5'(cmfp_pkg::HF_PEER_COUNT)) begin
                            peer_left = v[31:0];
                            fld = 0;
                            elem = 0;
                            if (ent_left > 0) ps = S_ENTRY;
                            else after_entries();
                        end
                    end
                end
                S_ENTRY: if (done) begin
                    add_field(cmfp_pkg::FC_ENT_BASE + f, v, elem, cmfp_pkg::ST_OK);
                    if (f == 5'(cmfp_pkg::EF_TYPE) && v > c_ent_type)
                        abort_frame(cmfp_pkg::ST_ENT_TYPE);
                    else if (f == 5'(cmfp_pkg::EF_DATA_LEN)) begin
                        pay_left = v[31:0];
                        fld = 0;
                        if (pay_left > 0) ps = S_EDATA;
                        else next_entry();
                    end
                end
                S_EDATA: begin
                    add_field(cmfp_pkg::FC_ENT_BYTE, {56'd0, b}, elem, cmfp_pkg::ST_OK);
                    pay_left = pay_left - 32'd1;
                    if (pay_left == 0) next_entry();
                end
                S_SNAP: begin
                    add_field(cmfp_pkg::FC_SNAP_BYTE, {56'd0, b}, 0, cmfp_pkg::ST_OK);
                    pay_left = pay_left - 32'd1;
                    if (pay_left == 0) to_peers();
                end
                S_PEER: if (done) begin
                    add_field(cmfp_pkg::FC_PEER_BASE + f, v, elem, cmfp_pkg::ST_OK);
                    if (f[0]) begin
                        if (v > 1) abort_frame(cmfp_pkg::ST_FLAG);
                        else begin
                            peer_left = peer_left - 32'd1;
                            elem = elem + 32'd1;
                            fld = 0;
                            if (peer_left == 0) ps = S_DONE;
                        end
                    end
                end
                S_DONE: abort_frame(cmfp_pkg::ST_TRAILING);
                default: ;
            endcase
        end
        if (e) begin
            if (err == cmfp_pkg::ST_OK && ps != S_DONE) err = cmfp_pkg::ST_TRUNC;
            add_field(cmfp_pkg::FC_VERDICT, {32'd0, tot}, 0, err);
            clear_frame();
        end
        if (step_fields.size() > 0) step_fields[$].lst = 1'b1;
        foreach (step_fields[k]) expected_fields.push_back(step_fields[k]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        if (!tx_steady) begin
            while ($urandom_range(99) < 37) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= e;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_byte(b, e);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            cmfp_pkg::REG_MAX_MSG_TYPE: c_msg_type = d[7:0];
            cmfp_pkg::REG_MAX_ENTRY_TYPE: c_ent_type = d[7:0];
            cmfp_pkg::REG_MAX_ENTRIES: c_entries = d;
            cmfp_pkg::REG_MAX_PEERS: c_peers = d;
            cmfp_pkg::REG_MAX_FRAME_BYTES: c_frame = d;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_be(input logic [63:0] v, input int n);
        for (int k = n - 1; k >= 0; k--) frame_bytes.push_back(v[8*k +: 8]);
    endtask

    function automatic logic [31:0] small_count(input logic [31:0] lim);
        return $urandom_range((lim < 3) ? lim : 3);
    endfunction

    // Builds a mostly well-formed frame and now and then breaks it; some are random bytes.
    task automatic build_frame();
        logic [31:0] ne, sl, np, dl;
        int          cut;
        frame_bytes.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
            return;
        end
        put_be(64'(($urandom_range(99) < 90) ? $urandom_range(c_msg_type)
                                             : $urandom_range(255)), 1);
        for (int k = 1; k <= 9; k++) put_be({$urandom, $urandom}, 8);
        put_be(64'(($urandom_range(99) < 93) ? $urandom_range(1) : $urandom_range(255)), 1);
        ne = ($urandom_range(99) < 90) ? small_count(c_entries) : $urandom;
        sl = ($urandom_range(99) < 90) ? $urandom_range(6) : $urandom;
        np = ($urandom_range(99) < 90) ? small_count(c_peers) : $urandom;
        put_be(64'(ne), 4);
        put_be(64'(sl), 4);
        put_be({$urandom, $urandom}, 8);
        put_be(64'(($urandom_range(99) < 93) ? $urandom_range(1) : $urandom_range(255)), 1);
        put_be(64'(np), 4);
        if (ne <= 3) begin
            for (int k = 0; k < ne; k++) begin
                put_be({$urandom, $urandom}, 8);
                put_be({$urandom, $urandom}, 8);
                put_be(64'(($urandom_range(99) < 90) ? $urandom_range(c_ent_type)
                                                     : $urandom_range(255)), 1);
                put_be({$urandom, $urandom}, 8);
                put_be({$urandom, $urandom}, 8);
                dl = ($urandom_range(99) < 95) ? $urandom_range(4) : $urandom;
                put_be(64'(dl), 4);
                if (dl <= 4) repeat (dl) frame_bytes.push_back(8'($urandom));
            end
        end
        if (sl <= 6) repeat (sl) frame_bytes.push_back(8'($urandom));
        if (np <= 3) begin
            for (int k = 0; k < np; k++) begin
                put_be({$urandom, $urandom}, 8);
                put_be(64'(($urandom_range(99) < 93) ? $urandom_range(1)
                                                     : $urandom_range(255)), 1);
            end
        end
        cut = $urandom_range(99);
        if (cut < 8) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end else if (cut < 15) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
        end else if (cut < 22) begin
            frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom);
        end
    endtask

    // Output side: random stalls and the comparison with the oldest prediction.
    always @(posedge i_clk) begin
        t_field_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected word, actual %h last %b", $time,
                         m_axis_tdata, m_axis_tlast);
                failures++;
            end else begin
                w = expected_fields.pop_front();
                if (m_axis_tdata[4:0] !== w.r.code || m_axis_tdata[68:5] !== w.r.value ||
                    m_axis_tdata[100:69] !== w.r.index ||
                    m_axis_tdata[104:101] !== w.r.status || m_axis_tlast !== w.lst) begin
                    $display("%0t: mismatch, expected code %0d value %h index %0d status %0d last %b",
                             $time, w.r.code, w.r.value, w.r.index, w.r.status, w.lst);
                    $display("%0t:           actual code %0d value %h index %0d status %0d last %b",
                             $time, m_axis_tdata[4:0], m_axis_tdata[68:5],
                             m_axis_tdata[100:69], m_axis_tdata[104:101], m_axis_tlast);
                    failures++;
                end
            end
        end
        m_axis_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 37);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[consensus_message_frame_parser] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dir_row rows[$];
        int       sent;
        logic [3:0] vs;
        c_msg_type = cmfp_pkg::MAX_MSG_TYPE_RST;
        c_ent_type = cmfp_pkg::MAX_ENTRY_TYPE_RST;
        c_entries = cmfp_pkg::MAX_ENTRIES_RST;
        c_peers = cmfp_pkg::MAX_PEERS_RST;
        c_frame = cmfp_pkg::MAX_FRAME_BYTES_RST;
        clear_frame();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short frames whose verdicts follow straight from the reset limits.
        rows = '{
            '{8'h00, 1'b1, 1'b1, cmfp_pkg::ST_TRUNC, 1},
            '{8'hFF, 1'b1, 1'b1, cmfp_pkg::ST_MSG_TYPE, 1},
            '{8'h0F, 1'b0, 1'b0, cmfp_pkg::ST_OK, 0},
            '{8'h00, 1'b1, 1'b1, cmfp_pkg::ST_TRUNC, 2},
            '{8'h10, 1'b0, 1'b0, cmfp_pkg::ST_OK, 0},
            '{8'hAA, 1'b0, 1'b0, cmfp_pkg::ST_OK, 0},
            '{8'h55, 1'b1, 1'b1, cmfp_pkg::ST_MSG_TYPE, 3},
            '{8'h00, 1'b0, 1'b0, cmfp_pkg::ST_OK, 0},
            '{8'hFF, 1'b0, 1'b0, cmfp_pkg::ST_OK, 0},
            '{8'h80, 1'b1, 1'b1, cmfp_pkg::ST_TRUNC, 3}
        };
        foreach (rows[k]) begin
            send_byte(rows[k].b, rows[k].e);
            if (rows[k].chk && (expected_fields[$].r.status !== rows[k].st ||
                                expected_fields[$].r.value !== 64'(rows[k].len))) begin
                $display("%0t: verdict mismatch, expected status %0d length %0d actual %0d %0d",
                         $time, rows[k].st, rows[k].len, expected_fields[$].r.status,
                         expected_fields[$].r.value);
                failures++;
            end
        end
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                1: begin
                    write_reg(cmfp_pkg::REG_MAX_MSG_TYPE, 32'hFF);
                    write_reg(cmfp_pkg::REG_MAX_ENTRY_TYPE, 32'hFF);
                    write_reg(cmfp_pkg::REG_MAX_ENTRIES, 32'hFFFF_FFFF);
                    write_reg(cmfp_pkg::REG_MAX_PEERS, 32'hFFFF_FFFF);
                    write_reg(cmfp_pkg::REG_MAX_FRAME_BYTES, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(cmfp_pkg::REG_MAX_MSG_TYPE, 32'd0);
                    write_reg(cmfp_pkg::REG_MAX_ENTRY_TYPE, 32'd0);
                    write_reg(cmfp_pkg::REG_MAX_ENTRIES, 32'd0);
                    write_reg(cmfp_pkg::REG_MAX_PEERS, 32'd0);
                    write_reg(cmfp_pkg::REG_MAX_FRAME_BYTES, 32'd95);
                end
                3: begin
                    write_reg(cmfp_pkg::REG_MAX_MSG_TYPE, $urandom_range(255));
                    write_reg(cmfp_pkg::REG_MAX_ENTRY_TYPE, $urandom_range(255));
                    write_reg(cmfp_pkg::REG_MAX_ENTRIES, $urandom_range(4));
                    write_reg(cmfp_pkg::REG_MAX_PEERS, $urandom_range(4));
                    write_reg(cmfp_pkg::REG_MAX_FRAME_BYTES, 32'(95 + $urandom_range(80)));
                end
                4: begin
                    write_reg(cmfp_pkg::REG_MAX_MSG_TYPE, 32'(cmfp_pkg::MAX_MSG_TYPE_RST));
                    write_reg(cmfp_pkg::REG_MAX_ENTRY_TYPE, 32'(cmfp_pkg::MAX_ENTRY_TYPE_RST));
                    write_reg(cmfp_pkg::REG_MAX_ENTRIES, cmfp_pkg::MAX_ENTRIES_RST);
                    write_reg(cmfp_pkg::REG_MAX_PEERS, cmfp_pkg::MAX_PEERS_RST);
                    write_reg(cmfp_pkg::REG_MAX_FRAME_BYTES, cmfp_pkg::MAX_FRAME_BYTES_RST);
                end
                default: ;
            endcase
            tx_steady = (p == 1);
            rx_steady <= (p == 1);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_frame();
                foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
                sent += frame_bytes.size();
                // In phase 3, past half its bytes, let the output side catch up after each frame.
                if (p == 3 && sent > PHASE_BYTES / 2) begin
                    s_axis_tvalid <= 1'b0;
                    while (expected_fields.size() != 0) @(posedge i_clk);
                end
            end
            wait_drained();
        end

        vs = (failures == 0 && expected_fields.size() == 0) ? 4'd1 : 4'd0;
        if (vs == 4'd1) begin
            $display("[consensus_message_frame_parser] OK");
        end else begin
            $display("[consensus_message_frame_parser] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/cmfp_pkg.sv
rtl/core/cmfp_front.sv
rtl/core/cmfp_back.sv
rtl/core/consensus_message_frame_parser.sv
tb/tb_consensus_message_frame_parser.sv
